/* sv/sssm_pkg.sv */
// Shared constants, command and register codes for the scrolling seven-segment multiplexer.
// Depends on nothing; imported by scrolling_seven_segment_multiplexer_core.
`default_nettype none

package sssm_pkg;

	localparam int MAX_DIGITS    = 8;
	localparam int SCROLL_DEPTH  = 64;
	localparam int SEGMENT_LINES = 8;

	// Scroll store addressing and the compare width for index/length checks
	localparam int ADDR_W = $clog2(SCROLL_DEPTH);
	localparam int IDX_W  = ADDR_W + 1;
	localparam int LEN_W  = 7;
	localparam int CMP_W  = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 1;

	localparam int POS_W = 4;
	localparam int SEL_W = 3;

	localparam logic [7:0] SEG_MASK = 8'((1 << SEGMENT_LINES) - 1);

	typedef enum logic [2:0] {
		CMD_TICK      = 3'd0,
		CMD_WR_STATIC = 3'd1,
		CMD_WR_SCROLL = 3'd2,
		CMD_START     = 3'd3,
		CMD_STOP      = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		REG_DIGIT_COUNT   = 2'd0,
		REG_HOLD_MS       = 2'd1,
		REG_REPEAT_COUNT  = 2'd2,
		REG_SCROLL_LENGTH = 2'd3
	} reg_idx_t;

	// One refresh tick on its way from the memory read to the output register
	typedef struct packed {
		logic       use_mem;
		logic [7:0] seg;
		logic [7:0] enables;
		logic       scrolling;
	} tick_t;

endpackage

`default_nettype wire

/* sv/scrolling_seven_segment_multiplexer_core.sv */
// Scrolling seven-segment multiplexer: one digit per refresh tick, scroll store in a RAM.
// Depends on sssm_pkg.
//
//   channel | direction | handshake              | payload
//   s_axis  | in        | tvalid/tready          | tuser command, tdata slot/pattern/now_ms
//   m_axis  | out       | tvalid/tready          | tuser scrolling, tdata segments/enables
//   cfg     | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// An item is taken every cycle unless the output stalls with the read stage full; a refresh
// tick reaches m_axis through the registered scroll RAM read and then the output register.
// Counters and window state update in the cycle a word is taken, so the next tick sees them.
// Reset clears counters, mode, static store and both valid flags; the scroll RAM is not cleared.
// A stalled output holds the read stage; s_axis_tready drops only when both are full.
`default_nettype none

module scrolling_seven_segment_multiplexer_core import sssm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // slot[5:0], pattern[13:6], now_ms[45:14], zero
	input  wire logic [2:0]  s_axis_tuser,  // command[2:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // segments[7:0], digit_enables[15:8]
	output logic [0:0]       m_axis_tuser,  // scrolling[0]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	// configuration
	logic [3:0]       digit_count_q;
	logic [15:0]      hold_ms_q;
	logic [7:0]       repeat_count_q;
	logic [LEN_W-1:0] scroll_length_q;

	// display state
	logic [7:0]        static_q [MAX_DIGITS];
	logic [7:0]        scroll_mem [SCROLL_DEPTH];
	logic [POS_W-1:0]  digit_pos_q;
	logic [ADDR_W-1:0] window_q;
	logic              scroll_active_q;
	logic [7:0]        repeats_left_q;
	logic [31:0]       hold_start_q;

	// pipeline
	logic        v_s1;
	tick_t       tick_s1;
	logic [7:0]  rd_s1;
	logic        out_valid_q;
	logic [15:0] out_data_q;
	logic        out_scroll_q;

	cmd_t             cmd;
	logic [5:0]       slot;
	logic [7:0]       pattern;
	logic [31:0]      now_ms;
	logic             accept;
	logic             tick_acc;
	logic             adv_s1;
	logic [POS_W-1:0] n_digits;
	logic [CMP_W-1:0] used_len;
	logic [POS_W-1:0] pos;
	logic [POS_W-1:0] pos_next;
	logic             sweep_end;
	logic [31:0]      elapsed;
	logic             hold_done;
	logic [CMP_W-1:0] idx;
	logic             idx_ok;
	logic             win_fits;
	tick_t            tick_new;

	assign cmd     = cmd_t'(s_axis_tuser);
	assign slot    = s_axis_tdata[5:0];
	assign pattern = s_axis_tdata[13:6];
	assign now_ms  = s_axis_tdata[45:14];

	assign adv_s1        = v_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !v_s1 || adv_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign tick_acc      = accept && (cmd == CMD_TICK);
	assign cfg_ready     = 1'b1;

	always_comb begin
		if (digit_count_q == '0) begin
			n_digits = POS_W'(1);
		end else if (digit_count_q > POS_W'(MAX_DIGITS)) begin
			n_digits = POS_W'(MAX_DIGITS);
		end else begin
			n_digits = digit_count_q;
		end
		if (CMP_W'(scroll_length_q) > CMP_W'(SCROLL_DEPTH)) begin
			used_len = CMP_W'(SCROLL_DEPTH);
		end else begin
			used_len = CMP_W'(scroll_length_q);
		end
		// restart when the digit count shrank under the position
		pos       = (digit_pos_q >= n_digits) ? '0 : digit_pos_q;
		pos_next  = pos + POS_W'(1);
		sweep_end = pos_next >= n_digits;
		elapsed   = now_ms - hold_start_q;
		hold_done = elapsed > {16'd0, hold_ms_q};
		idx       = CMP_W'(window_q) + CMP_W'(pos);
		idx_ok    = idx < used_len;
		win_fits  = (CMP_W'(window_q) + CMP_W'(n_digits)) < used_len;

		tick_new.use_mem   = scroll_active_q && idx_ok;
		tick_new.seg       = scroll_active_q ? 8'd0 : static_q[pos[SEL_W-1:0]];
		tick_new.enables   = ~(8'd1 << pos[SEL_W-1:0]);
		tick_new.scrolling = scroll_active_q;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q   <= 4'd4;
			hold_ms_q       <= 16'd500;
			repeat_count_q  <= 8'd0;
			scroll_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DIGIT_COUNT:   digit_count_q   <= cfg_data[3:0];
				REG_HOLD_MS:       hold_ms_q       <= cfg_data;
				REG_REPEAT_COUNT:  repeat_count_q  <= cfg_data[7:0];
				REG_SCROLL_LENGTH: scroll_length_q <= cfg_data[LEN_W-1:0];
			endcase
		end
	end

	// static store and scroll state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_DIGITS; i++) begin
				static_q[i] <= 8'd0;
			end
			digit_pos_q     <= '0;
			window_q        <= '0;
			scroll_active_q <= 1'b0;
			repeats_left_q  <= 8'd0;
			hold_start_q    <= 32'd0;
		end else if (accept) begin
			unique case (cmd)
				CMD_WR_STATIC: begin
					if (POS_W'(slot) < n_digits && slot < 6'(MAX_DIGITS)) begin
						static_q[slot[SEL_W-1:0]] <= pattern;
					end
				end
				CMD_START: begin
					scroll_active_q <= 1'b1;
					window_q        <= '0;
					digit_pos_q     <= '0;
					repeats_left_q  <= repeat_count_q;
					hold_start_q    <= now_ms;
				end
				CMD_STOP: begin
					scroll_active_q <= 1'b0;
				end
				CMD_TICK: begin
					if (!scroll_active_q) begin
						digit_pos_q <= pos_next;
					end else if (!sweep_end) begin
						digit_pos_q <= pos_next;
					end else begin
						digit_pos_q <= '0;
						if (hold_done) begin
							hold_start_q <= now_ms;
							if (win_fits) begin
								window_q <= window_q + ADDR_W'(1);
							end else begin
								window_q <= '0;
								// zero ends the run; negative repeats forever
								if (repeats_left_q == 8'd0) begin
									scroll_active_q <= 1'b0;
								end else if (!repeats_left_q[7]) begin
									repeats_left_q <= repeats_left_q - 8'd1;
								end
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// scroll RAM: write on store command, registered read on every refresh tick
	always_ff @(posedge clk) begin
		if (accept && cmd == CMD_WR_SCROLL && CMP_W'(slot) < CMP_W'(SCROLL_DEPTH)) begin
			scroll_mem[slot[ADDR_W-1:0]] <= pattern;
		end
		if (tick_acc) begin
			rd_s1   <= scroll_mem[idx[ADDR_W-1:0]];
			tick_s1 <= tick_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tick_acc) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q[7:0]  <= (tick_s1.use_mem ? rd_s1 : tick_s1.seg) & SEG_MASK;
			out_data_q[15:8] <= tick_s1.enables;
			out_scroll_q     <= tick_s1.scrolling;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_scroll_q;

	a_one_digit_low: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $countones(~m_axis_tdata[15:8]) == 1)
		else $error("digit enables not one-cold");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while read stage is stuck");

	a_tick_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> v_s1)
		else $error("accepted tick lost before read stage");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		digit_pos_q <= POS_W'(MAX_DIGITS))
		else $error("digit position beyond display");

endmodule

`default_nettype wire
